// ----- design/pnc_pkg.sv -----
package pnc_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_IDX_W = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int COMP_W = 16;
	localparam int IDX_W = 8;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(3 * ((1 << COMP_W) - 1));

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
	} color_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic vld;
		logic [PAL_IDX_W-1:0] idx;
		color_t entry;
	} issue_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} pnc_state_t;

endpackage

// ----- design/nearest_palette_color_search_top.sv -----
// Nearest palette color search (L1 distance). The palette lives in a ring of
// PAL_ENTRIES cells, cleared to black at reset. A write beat stores one entry
// and gives no result. A query beat rotates the ring once, one entry per
// cycle through a two-stage distance unit, and the result is loaded once that
// unit has drained and the output register is free. Inputs are not taken while
// a query is in flight; a query result waits in an output register until
// taken, and writes are accepted meanwhile. Ties go to the lowest index.
module nearest_palette_color_search_top
	import pnc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [COMP_W-1:0] red,
	input  logic [COMP_W-1:0] green,
	input  logic [COMP_W-1:0] blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  nearest_index,
	output logic [DIST_W-1:0] nearest_distance
);

	localparam logic [PAL_IDX_W-1:0] LAST_IDX = PAL_IDX_W'(PAL_ENTRIES - 1);

	pnc_state_t state_q;
	pnc_state_t state_d;

	logic [PAL_IDX_W-1:0] cnt_q;
	color_t               tgt_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     nearest_index_q;
	logic [DIST_W-1:0]    nearest_distance_q;

	logic   in_beat;
	logic   wr_go;
	logic   scan_go;
	logic   out_load;
	logic   pipe_busy;
	color_t in_color;
	issue_t issue;

	logic [PAL_IDX_W-1:0] best_idx;
	logic [DIST_W-1:0]    best_dist;

	color_t cell_q [PAL_ENTRIES];

	assign in_beat  = in_valid && in_ready;
	assign wr_go    = in_beat && (kind == KIND_WRITE);
	assign in_color = '{r: red, g: green, b: blue};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat && kind == KIND_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		scan_go  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scan_go = 1'b1;
			ST_DRAIN: out_load = !pipe_busy && (!out_valid_q || out_ready);
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (scan_go) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && kind == KIND_QUERY) begin
			tgt_q <= in_color;
		end
	end

	// ring of cells: head is cell 0, each cell takes its upper neighbor
	genvar i;
	generate
		for (i = 0; i < PAL_ENTRIES; i++) begin : g_cell
			cell_ctl_t ctl;
			assign ctl.load  = wr_go && (32'(entry_index) == 32'(i));
			assign ctl.shift = scan_go;
			pnc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.wr_data (in_color),
				.nb_data (cell_q[(i + 1) % PAL_ENTRIES]),
				.q       (cell_q[i])
			);
		end
	endgenerate

	assign issue.vld   = scan_go;
	assign issue.idx   = cnt_q;
	assign issue.entry = cell_q[0];

	pnc_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.tgt       (tgt_q),
		.busy      (pipe_busy),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			nearest_index_q    <= IDX_W'(best_idx);
			nearest_distance_q <= best_dist;
		end
	end

	assign out_valid        = out_valid_q;
	assign nearest_index    = nearest_index_q;
	assign nearest_distance = nearest_distance_q;

	a_scan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !in_ready)
		else $error("input taken during scan");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && cnt_q == LAST_IDX |=> state_q == ST_DRAIN && cnt_q == '0)
		else $error("scan did not end after last entry");

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pipe_busy)
		else $error("distance pipeline busy while idle");

	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_DRAIN && !pipe_busy)
		else $error("result loaded before pipeline drained");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> nearest_distance_q <= DIST_MAX)
		else $error("distance out of range");

endmodule

// ----- design/pnc_cell.sv -----
module pnc_cell
	import pnc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  color_t    wr_data,
	input  color_t    nb_data,
	output color_t    q
);

	color_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.load) begin
			entry_q <= wr_data;
		end else if (ctl.shift) begin
			entry_q <= nb_data;
		end
	end

	assign q = entry_q;

endmodule

// ----- design/pnc_dist.sv -----
module pnc_dist
	import pnc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  issue_t                issue,
	input  color_t                tgt,
	output logic                  busy,
	output logic [PAL_IDX_W-1:0]  best_idx,
	output logic [DIST_W-1:0]     best_dist
);

	logic                 v_s1;
	logic [PAL_IDX_W-1:0] idx_s1;
	logic [COMP_W-1:0]    dr_s1;
	logic [COMP_W-1:0]    dg_s1;
	logic [COMP_W-1:0]    db_s1;

	logic                 v_s2;
	logic [PAL_IDX_W-1:0] idx_s2;
	logic [DIST_W-1:0]    dist_s2;

	logic [PAL_IDX_W-1:0] best_idx_q;
	logic [DIST_W-1:0]    best_dist_q;

	logic [COMP_W-1:0] dr;
	logic [COMP_W-1:0] dg;
	logic [COMP_W-1:0] db;

	always_comb begin
		dr = (tgt.r >= issue.entry.r) ? tgt.r - issue.entry.r : issue.entry.r - tgt.r;
		dg = (tgt.g >= issue.entry.g) ? tgt.g - issue.entry.g : issue.entry.g - tgt.g;
		db = (tgt.b >= issue.entry.b) ? tgt.b - issue.entry.b : issue.entry.b - tgt.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue.vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= issue.idx;
		dr_s1   <= dr;
		dg_s1   <= dg;
		db_s1   <= db;
		idx_s2  <= idx_s1;
		dist_s2 <= DIST_W'(dr_s1) + DIST_W'(dg_s1) + DIST_W'(db_s1);
	end

	// strict less-than keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q  <= '0;
			best_dist_q <= '0;
		end else if (v_s2 && (idx_s2 == '0 || dist_s2 < best_dist_q)) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
		end
	end

	assign busy      = v_s1 | v_s2;
	assign best_idx  = best_idx_q;
	assign best_dist = best_dist_q;

endmodule
